/* design/svalloc_pkg.sv */
package svalloc_pkg;

  localparam int VOICES = 8;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NOTE_W = 7;
  localparam int VOUT_W = 3;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [NOTE_W-1:0] note_t;
  typedef logic [VOUT_W-1:0] vout_t;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_FINISHED = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    OC_ASSIGNED = 3'd0,
    OC_STOLEN   = 3'd1,
    OC_RELEASED = 3'd2,
    OC_NO_MATCH = 3'd3,
    OC_CLEARED  = 3'd4,
    OC_IGNORED  = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // voice table write request
  typedef struct packed {
    logic  set;
    logic  clr;
    vidx_t idx;
    note_t note;
  } tbl_wr_t;

  // one finished result
  typedef struct packed {
    vout_t    voice_out;
    outcome_t outcome;
    logic     key_held;
  } res_t;

  // low bits of a voice index, zero-extended when the index is narrow
  function automatic vout_t to_vout(vidx_t idx);
    return VOUT_W'(idx);
  endfunction

endpackage

/* design/svalloc_ifs.sv */
interface svalloc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] note;
  logic [2:0] voice;

  modport source(output valid, output op, output note, output voice, input ready);
  modport sink(input valid, input op, input note, input voice, output ready);
endinterface

interface svalloc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] voice_out;
  logic [2:0] outcome;
  logic       key_held;

  modport source(output valid, output voice_out, output outcome, output key_held,
                 input ready);
  modport sink(input valid, input voice_out, input outcome, input key_held,
               output ready);
endinterface

/* design/svalloc_table.sv */
module svalloc_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svalloc_pkg::vidx_t    rd_idx,
  input  svalloc_pkg::tbl_wr_t  wr,
  output logic                  rd_busy,
  output svalloc_pkg::note_t    rd_note
);

  logic [svalloc_pkg::VOICES-1:0] busy_r;
  svalloc_pkg::note_t             note_r [svalloc_pkg::VOICES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (wr.set) begin
      busy_r[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      busy_r[wr.idx] <= 1'b0;
    end
  end

  // notes are only read while busy, so no reset
  always_ff @(posedge clk) begin
    if (wr.set) begin
      note_r[wr.idx] <= wr.note;
    end
  end

  assign rd_busy = busy_r[rd_idx];
  assign rd_note = note_r[rd_idx];

endmodule

/* design/svalloc_ctrl.sv */
module svalloc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_op,
  input  logic [6:0]            in_note,
  input  logic [2:0]            in_voice,
  input  logic                  out_free,
  output logic                  res_load,
  output svalloc_pkg::res_t     res,
  output svalloc_pkg::vidx_t    rd_idx,
  input  logic                  rd_busy,
  input  svalloc_pkg::note_t    rd_note,
  output svalloc_pkg::tbl_wr_t  wr
);

  svalloc_pkg::state_t state_r, state_nxt;
  svalloc_pkg::op_t    op_r;
  svalloc_pkg::note_t  note_r;
  logic [2:0]          vin_r;
  logic                inrange_r;
  svalloc_pkg::vidx_t  cnt_r;
  logic                free_found_r, best_valid_r, match_found_r, any_busy_r, hit_r;
  svalloc_pkg::vidx_t  free_idx_r, best_idx_r, match_idx_r;
  svalloc_pkg::note_t  best_note_r;
  logic                key_flag_r;

  logic accept, scan_last, fire;
  logic lower, same;
  svalloc_pkg::res_t   res_c;
  svalloc_pkg::tbl_wr_t wr_c;

  assign accept    = in_valid && in_ready;
  assign scan_last = (cnt_r == svalloc_pkg::VIDX_W'(svalloc_pkg::VOICES - 1));
  assign fire      = (state_r == svalloc_pkg::ST_RESP) && out_free;

  // shared compare unit, one voice per cycle
  assign lower = rd_busy && (!best_valid_r || (rd_note < best_note_r));
  assign same  = rd_busy && (rd_note == note_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svalloc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (svalloc_pkg::op_t'(in_op) == svalloc_pkg::OP_UNUSED) ?
                      svalloc_pkg::ST_RESP : svalloc_pkg::ST_SCAN;
        end
      end
      svalloc_pkg::ST_SCAN: begin
        if (op_r == svalloc_pkg::OP_FINISHED || scan_last) begin
          state_nxt = svalloc_pkg::ST_RESP;
        end
      end
      svalloc_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = svalloc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = svalloc_pkg::ST_IDLE;
    endcase
  end

  // result and table update, from the scan summary
  always_comb begin
    res_c = '{voice_out: '0, outcome: svalloc_pkg::OC_IGNORED, key_held: key_flag_r};
    wr_c  = '{set: 1'b0, clr: 1'b0, idx: '0, note: note_r};
    case (op_r)
      svalloc_pkg::OP_NOTE_ON: begin
        wr_c.set       = 1'b1;
        wr_c.idx       = free_found_r ? free_idx_r : best_idx_r;
        res_c.voice_out = svalloc_pkg::to_vout(wr_c.idx);
        res_c.outcome  = free_found_r ? svalloc_pkg::OC_ASSIGNED : svalloc_pkg::OC_STOLEN;
        res_c.key_held = 1'b1;
      end
      svalloc_pkg::OP_NOTE_OFF: begin
        if (match_found_r) begin
          res_c.voice_out = svalloc_pkg::to_vout(match_idx_r);
          res_c.outcome   = svalloc_pkg::OC_RELEASED;
        end else begin
          res_c.outcome   = svalloc_pkg::OC_NO_MATCH;
        end
        res_c.key_held = key_flag_r && any_busy_r;
      end
      svalloc_pkg::OP_FINISHED: begin
        res_c.voice_out = vin_r;
        wr_c.clr        = hit_r;
        wr_c.idx        = cnt_r;
        res_c.outcome   = hit_r ? svalloc_pkg::OC_CLEARED : svalloc_pkg::OC_IGNORED;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == svalloc_pkg::ST_IDLE);
    rd_idx   = cnt_r;
    res_load = fire;
    res      = res_c;
    wr       = wr_c;
    wr.set   = wr_c.set && fire;
    wr.clr   = wr_c.clr && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= svalloc_pkg::ST_IDLE;
      key_flag_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        key_flag_r <= res_c.key_held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= svalloc_pkg::op_t'(in_op);
      note_r        <= in_note;
      vin_r         <= in_voice;
      inrange_r     <= (int'(in_voice) < svalloc_pkg::VOICES);
      cnt_r         <= (svalloc_pkg::op_t'(in_op) == svalloc_pkg::OP_FINISHED) ?
                       svalloc_pkg::VIDX_W'(in_voice) : '0;
      free_found_r  <= 1'b0;
      best_valid_r  <= 1'b0;
      match_found_r <= 1'b0;
      any_busy_r    <= 1'b0;
      hit_r         <= 1'b0;
      free_idx_r    <= '0;
      best_idx_r    <= '0;
      match_idx_r   <= '0;
      best_note_r   <= '0;
    end else if (state_r == svalloc_pkg::ST_SCAN) begin
      if (op_r == svalloc_pkg::OP_FINISHED) begin
        hit_r <= inrange_r && rd_busy;
      end else begin
        any_busy_r <= any_busy_r || rd_busy;
        if (!rd_busy && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cnt_r;
        end
        if (lower) begin
          best_valid_r <= 1'b1;
          best_idx_r   <= cnt_r;
          best_note_r  <= rd_note;
        end
        if (same && !match_found_r) begin
          match_found_r <= 1'b1;
          match_idx_r   <= cnt_r;
        end
        if (!scan_last) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

endmodule

/* design/synth_voice_allocator.sv */
// Channel   Dir  Fields                              Transfer
// in_ch     in   op[1:0] note[6:0] voice[2:0]        valid && ready
// out_ch    out  voice_out[2:0] outcome[2:0] key_held valid && ready
//
// Note-on / note-off: the transfer cycle, then one voice per cycle through the
//   shared compare unit, then one update that loads the result register.
// Voice finished: the transfer, one table lookup, then the update.
//   Unused op: the transfer, then the update.
// in_ch.ready is high only while the sequencer is idle.
// One output register; the next item is taken while a result waits, and the
//   sequencer holds its update until the output register frees up.
// Synchronous active-low reset clears all busy flags and the key-held flag.
module synth_voice_allocator (
  input  logic          clk,
  input  logic          rst_n,
  svalloc_in_if.sink    in_ch,
  svalloc_out_if.source out_ch
);

  svalloc_pkg::vidx_t   rd_idx;
  logic                 rd_busy;
  svalloc_pkg::note_t   rd_note;
  svalloc_pkg::tbl_wr_t wr;
  svalloc_pkg::res_t    res;
  logic                 res_load;
  logic                 out_free;

  logic                 out_valid_r;
  svalloc_pkg::res_t    out_res_r;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  svalloc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_idx),
    .wr      (wr),
    .rd_busy (rd_busy),
    .rd_note (rd_note)
  );

  svalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_op    (in_ch.op),
    .in_note  (in_ch.note),
    .in_voice (in_ch.voice),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .rd_idx   (rd_idx),
    .rd_busy  (rd_busy),
    .rd_note  (rd_note),
    .wr       (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.voice_out = out_res_r.voice_out;
  assign out_ch.outcome   = out_res_r.outcome;
  assign out_ch.key_held  = out_res_r.key_held;

`ifndef SYNTH
  // sequencer goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("ready stayed high after an input transfer");

  // a result that assigns, steals or releases a voice carries the key-held flag
  a_key_with_voice: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.outcome == svalloc_pkg::OC_ASSIGNED ||
                     out_ch.outcome == svalloc_pkg::OC_STOLEN ||
                     out_ch.outcome == svalloc_pkg::OC_RELEASED) |-> out_ch.key_held)
    else $error("key_held low with a busy voice");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");
`endif

endmodule
